// ===== rtl/crc16_checked_frame_receiver_macros.svh =====
// Assertion helpers for the RTL, used by ccfr_core. Each expects clk and rst_n in scope.
`ifndef CRC16_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define CRC16_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CCFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define CCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ccfr_pkg.sv =====
package ccfr_pkg;

  localparam int ByteW   = 8;
  localparam int CrcW    = 16;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LAST_INDEX = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CRC_POLY   = 2'd3;

  // Register reset values
  localparam logic [ByteW-1:0] START_BYTE_RST = 8'h02;
  localparam logic [ByteW-1:0] END_BYTE_RST   = 8'h03;
  localparam logic [ByteW-1:0] LAST_INDEX_RST = 8'd16;
  localparam logic [CrcW-1:0]  CRC_POLY_RST   = 16'h5105;

  // Shortest frame that still leaves room for the two CRC bytes
  localparam logic [ByteW-1:0] MIN_LAST_INDEX = 8'd4;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [ByteW-1:0] last_index;
    logic [CrcW-1:0]  crc_poly;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] position;
    logic             in_frame;
    logic             frame_end;
    logic             frame_good;
  } res_t;

endpackage

// ===== rtl/ccfr_ifs.sv =====
interface ccfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [ccfr_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [ccfr_pkg::ByteW-1:0] data_byte;
  logic [ccfr_pkg::ByteW-1:0] position;
  logic                      in_frame;
  logic                      frame_end;
  logic                      frame_good;

  modport source (output valid, output data_byte, output position, output in_frame,
                  output frame_end, output frame_good, input ready);
  modport sink   (input valid, input data_byte, input position, input in_frame,
                  input frame_end, input frame_good, output ready);
endinterface

// ===== rtl/crc16_checked_frame_receiver.sv =====
// Framed byte receiver with CRC-16 check.
// in_ch carries one received serial byte per word (rx_byte). out_ch returns one
// word per input word: the byte echoed, its frame position, and in_frame,
// frame_end and frame_good flags. Both channels move a word when valid and
// ready are high together at a rising edge of clk.
// The cfg port (cfg_we, cfg_index, cfg_wdata) writes start byte, end byte,
// last index and CRC polynomial; write it only while no word is in flight.
// A word accepted from in_ch sits in the input register, is decoded and
// loaded into the result register when that register is free, and is
// offered on out_ch from then on. Throughput: one word every cycle while
// out_ch does not stall, set by the combinational update of the frame
// position and CRC registers (eight unrolled CRC bits).
// Reset (rst_n low at a clock edge) returns the registers to their defaults
// (start 0x02, end 0x03, last index 16, polynomial 0x5105), hunting for a
// start byte with zero CRCs, and empties both pipeline registers.
// When the receiver stalls out_ch, the result word holds; the input register
// then fills and in_ch.ready drops until out_ch takes a word. No word is
// ever lost or repeated.
module crc16_checked_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  ccfr_in_if.sink                       in_ch,
  ccfr_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ccfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ccfr_pkg::CrcW-1:0]     cfg_wdata
);

  ccfr_pkg::cfg_t             cfg;
  ccfr_pkg::res_t             res;
  logic                       fire;
  logic                       down_ready;
  logic [ccfr_pkg::ByteW-1:0] byte_q;

  // Register file for the four settings
  ccfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register: hold the incoming word until the result register is free
  ccfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .down_ready (down_ready),
    .fire       (fire),
    .byte_q     (byte_q)
  );

  // Frame tracking and CRC: advance the state once per word moved on
  ccfr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .byte_q (byte_q),
    .res    (res)
  );

  // Result register: hold the word while out_ch stalls
  ccfr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res      (res),
    .up_ready (down_ready),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/ccfr_cfg_regs.sv =====
module ccfr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ccfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ccfr_pkg::CrcW-1:0]     cfg_wdata,
  output ccfr_pkg::cfg_t                cfg
);

  ccfr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= ccfr_pkg::START_BYTE_RST;
      cfg_r.end_byte   <= ccfr_pkg::END_BYTE_RST;
      cfg_r.last_index <= ccfr_pkg::LAST_INDEX_RST;
      cfg_r.crc_poly   <= ccfr_pkg::CRC_POLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ccfr_pkg::CFG_START_BYTE: cfg_r.start_byte <= cfg_wdata[ccfr_pkg::ByteW-1:0];
        ccfr_pkg::CFG_END_BYTE:   cfg_r.end_byte   <= cfg_wdata[ccfr_pkg::ByteW-1:0];
        ccfr_pkg::CFG_LAST_INDEX: cfg_r.last_index <= cfg_wdata[ccfr_pkg::ByteW-1:0];
        ccfr_pkg::CFG_CRC_POLY:   cfg_r.crc_poly   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ccfr_in_stage.sv =====
module ccfr_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  ccfr_in_if.sink                    in_ch,
  input  logic                       down_ready,
  output logic                       fire,
  output logic [ccfr_pkg::ByteW-1:0] byte_q
);

  logic                       s1_v_r;
  logic [ccfr_pkg::ByteW-1:0] s1_byte_r;

  // Take a word when empty or when the held word moves on this cycle
  assign in_ch.ready = !s1_v_r || down_ready;
  assign fire        = s1_v_r && down_ready;
  assign byte_q      = s1_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

endmodule

// ===== rtl/ccfr_crc8.sv =====
module ccfr_crc8 (
  input  logic [ccfr_pkg::CrcW-1:0]  crc_in,
  input  logic [ccfr_pkg::ByteW-1:0] data,
  input  logic [ccfr_pkg::CrcW-1:0]  poly,
  output logic [ccfr_pkg::CrcW-1:0]  crc_out
);

  // MSB-first, one bit per step, eight steps per byte
  always_comb begin
    crc_out = crc_in ^ {data, {(ccfr_pkg::CrcW-ccfr_pkg::ByteW){1'b0}}};
    for (int i = 0; i < ccfr_pkg::ByteW; i++) begin
      if (crc_out[ccfr_pkg::CrcW-1]) begin
        crc_out = {crc_out[ccfr_pkg::CrcW-2:0], 1'b0} ^ poly;
      end else begin
        crc_out = {crc_out[ccfr_pkg::CrcW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/ccfr_core.sv =====
`include "crc16_checked_frame_receiver_macros.svh"

module ccfr_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ccfr_pkg::cfg_t             cfg,
  input  logic                       fire,
  input  logic [ccfr_pkg::ByteW-1:0] byte_q,
  output ccfr_pkg::res_t             res
);

  logic [ccfr_pkg::ByteW-1:0] pos_r, pos_nxt;
  logic [ccfr_pkg::CrcW-1:0]  crc_r, crc_nxt;
  logic [ccfr_pkg::CrcW-1:0]  rcv_r, rcv_nxt;
  logic [ccfr_pkg::CrcW-1:0]  crc_seed, crc_upd;
  logic [ccfr_pkg::ByteW+1:0] pos_ext, last_ext;
  logic                       in_crc_span, at_crc_hi;

  // Start byte restarts the CRC from zero
  assign crc_seed = (pos_r == '0) ? '0 : crc_r;

  ccfr_crc8 u_crc8 (
    .crc_in  (crc_seed),
    .data    (byte_q),
    .poly    (cfg.crc_poly),
    .crc_out (crc_upd)
  );

  assign pos_ext     = {2'b00, pos_r};
  assign last_ext    = {2'b00, cfg.last_index};
  assign in_crc_span = (pos_ext + 10'd3) <= last_ext;
  assign at_crc_hi   = (pos_ext + 10'd2) == last_ext;

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    rcv_nxt        = rcv_r;
    res.data_byte  = byte_q;
    res.position   = '0;
    res.in_frame   = 1'b0;
    res.frame_end  = 1'b0;
    res.frame_good = 1'b0;
    if (pos_r == '0) begin
      if (byte_q == cfg.start_byte) begin
        crc_nxt      = crc_upd;
        pos_nxt      = 8'd1;
        res.in_frame = 1'b1;
      end
    end else if (pos_r == 8'd1) begin
      if (byte_q == cfg.last_index && cfg.last_index >= ccfr_pkg::MIN_LAST_INDEX) begin
        if (in_crc_span) begin
          crc_nxt = crc_upd;
        end
        pos_nxt      = 8'd2;
        res.position = pos_r;
        res.in_frame = 1'b1;
      end else begin
        pos_nxt = '0;
      end
    end else begin
      res.position = pos_r;
      res.in_frame = 1'b1;
      if (pos_r >= cfg.last_index) begin
        res.frame_end  = 1'b1;
        res.frame_good = (byte_q == cfg.end_byte) && (crc_r == rcv_r);
        pos_nxt        = '0;
      end else begin
        if (in_crc_span) begin
          crc_nxt = crc_upd;
        end else if (at_crc_hi) begin
          rcv_nxt = {byte_q, rcv_r[ccfr_pkg::ByteW-1:0]};
        end else begin
          rcv_nxt = {rcv_r[ccfr_pkg::CrcW-1:ccfr_pkg::ByteW], byte_q};
        end
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= '0;
      rcv_r <= '0;
    end else if (fire) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      rcv_r <= rcv_nxt;
    end
  end

  `CCFR_ASSERT_NEXT(a_end_returns_to_hunt, rst_n && fire && res.frame_end, pos_r == '0, "frame end did not return to hunting")
  `CCFR_ASSERT_NEXT(a_idle_holds_state, rst_n && !fire, $stable(pos_r) && $stable(crc_r) && $stable(rcv_r), "frame state moved without a word")
  `CCFR_ASSERT_NOW(a_good_needs_end, res.frame_good, res.frame_end && res.position >= 8'd2, "good flag outside a frame end")
  `CCFR_ASSERT_NEXT(a_reject_keeps_hunting, rst_n && fire && !res.in_frame, pos_r == '0, "rejected word left the hunt")

endmodule

// ===== rtl/ccfr_out_stage.sv =====
module ccfr_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  ccfr_pkg::res_t res,
  output logic           up_ready,
  ccfr_out_if.source     out_ch
);

  logic           out_v_r;
  ccfr_pkg::res_t res_r;

  // Free when empty or when the held word is taken this cycle
  assign up_ready = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.data_byte  = res_r.data_byte;
  assign out_ch.position   = res_r.position;
  assign out_ch.in_frame   = res_r.in_frame;
  assign out_ch.frame_end  = res_r.frame_end;
  assign out_ch.frame_good = res_r.frame_good;

endmodule
